/* src/mcpv_pkg.sv */
// ----------------------------------------------------------------------------
// mcpv_pkg
// Shared types, constants and helpers of the multi-camera visibility counter.
// ----------------------------------------------------------------------------
package mcpv_pkg;

  localparam int unsigned MAX_CAMERAS_DEFAULT = 8;
  localparam int unsigned COEFFS_PER_CAMERA   = 12;
  localparam int unsigned COEFF_SLOT_W        = 4;   // 16 slots per camera, 12 used
  localparam int unsigned COEFF_W             = 32;
  localparam int unsigned PROD_W              = 64;
  localparam int unsigned ACC_W               = 50;  // camera coordinate, signed
  localparam int unsigned MAG_W               = 49;
  localparam int unsigned CMP_W               = 16 + MAG_W;
  localparam int unsigned COLORMAP_ENTRIES    = 10;
  localparam int unsigned VIS_SAT             = 15;
  localparam int unsigned MASKED_CAMERAS      = 8;   // cameras with an enable bit

  // configuration reset values
  localparam logic [3:0]  CAMERA_COUNT_RST  = 4'd0;
  localparam logic [7:0]  ENABLE_MASK_RST   = 8'd255;
  localparam logic [15:0] FOCAL_LENGTH_RST  = 16'd3118;
  localparam logic [15:0] HALF_SENSOR_RST   = 16'd1800;
  localparam logic [2:0]  OCC_THRESHOLD_RST = 3'd0;

  typedef enum logic [7:0] {
    CFG_CAMERA_COUNT  = 8'd0,
    CFG_ENABLE_MASK   = 8'd1,
    CFG_FOCAL_LENGTH  = 8'd2,
    CFG_HALF_SENSOR   = 8'd3,
    CFG_OCC_THRESHOLD = 8'd4
  } cfg_reg_e;

  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_TEST = 1'b1
  } req_type_e;

  // write side of the coefficient store
  typedef struct packed {
    logic               en;
    logic [COEFF_W-1:0] data;
  } ram_wr_t;

  // output row that a coefficient slot feeds: 0..8 by row, 9..11 translation
  function automatic logic [1:0] coeff_row(input logic [COEFF_SLOT_W-1:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2, 4'd9: r = 2'd0;
      4'd3, 4'd4, 4'd5, 4'd10: r = 2'd1;
      default: r = 2'd2;
    endcase
    return r;
  endfunction

  // point coordinate that a rotation slot multiplies
  function automatic logic [1:0] coeff_col(input logic [COEFF_SLOT_W-1:0] k);
    logic [1:0] c;
    case (k)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default: c = 2'd2;
    endcase
    return c;
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] a;
    a = v[ACC_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

endpackage

/* src/mcpv_coeff_ram.sv */
// ----------------------------------------------------------------------------
// mcpv_coeff_ram
// Single-port-write, single-port-read coefficient store, registered read.
// ----------------------------------------------------------------------------
module mcpv_coeff_ram #(
  parameter int unsigned ADDR_W = 7
) (
  input  logic                             clk_i,
  input  mcpv_pkg::ram_wr_t                wr_i,
  input  logic [ADDR_W-1:0]                waddr_i,
  input  logic                             re_i,
  input  logic [ADDR_W-1:0]                raddr_i,
  output logic [mcpv_pkg::COEFF_W-1:0]     rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [mcpv_pkg::COEFF_W-1:0] mem_q [DEPTH];
  logic [mcpv_pkg::COEFF_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[waddr_i] <= wr_i.data;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/multi_camera_point_visibility.sv */
// ----------------------------------------------------------------------------
// multi_camera_point_visibility
// Counts the enabled cameras whose pinhole frustum contains a world point; a lone camera facing away gives -1.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  ------    ---------                  -------
//  request   start_i, busy_o            req_type_i, camera_index_i, coeff_index_i,
//                                       coeff_value_i, point_x_i/y_i/z_i
//  result    result_valid_o (strobe)    visibility_o, color_index_o, mark_occupied_o
//  config    cfg_valid_i, cfg_ready_o   cfg_index_i, cfg_data_i
//
//  A load beat writes the coefficient store at the accepting edge and does
//  not raise busy_o. In a test beat each enabled camera streams its 12
//  coefficients through the single read port and one shared 32x32
//  multiplier, then three passes of a 16x49 multiplier do the frustum
//  compare. The result strobe lasts one cycle and the receiver cannot
//  stall it. No clearing pass after reset.
// ----------------------------------------------------------------------------
module multi_camera_point_visibility #(
  parameter int unsigned MAX_CAMERAS = mcpv_pkg::MAX_CAMERAS_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [2:0]         camera_index_i,
  input  logic [3:0]         coeff_index_i,
  input  logic signed [31:0] coeff_value_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  output logic               result_valid_o,
  output logic signed [4:0]  visibility_o,
  output logic [3:0]         color_index_o,
  output logic               mark_occupied_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned CAM_W  = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_CAMERAS + 1);
  localparam int unsigned ADDR_W = CAM_W + mcpv_pkg::COEFF_SLOT_W;
  localparam int unsigned ACC_W  = mcpv_pkg::ACC_W;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_CAM    = 9'b000000010,
    ST_ISSUE  = 9'b000000100,
    ST_DRAIN  = 9'b000001000,
    ST_CMP_Z  = 9'b000010000,
    ST_CMP_X  = 9'b000100000,
    ST_CMP_Y  = 9'b001000000,
    ST_DECIDE = 9'b010000000,
    ST_FINISH = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [3:0]  camera_count_q;
  logic [7:0]  enable_mask_q;
  logic [15:0] focal_length_q;
  logic [15:0] half_sensor_q;
  logic [2:0]  occ_threshold_q;

  // item state
  logic signed [31:0]             point_q [3];
  logic [CNT_W-1:0]               cam_q;
  logic [mcpv_pkg::COEFF_SLOT_W-1:0] k_q;
  logic signed [4:0]              vis_q;
  logic signed [ACC_W-1:0]        acc_q [3];

  // coefficient pipeline
  logic                              s1_valid_q, s2_valid_q;
  logic [mcpv_pkg::COEFF_SLOT_W-1:0] s1_k_q, s2_k_q;
  logic signed [mcpv_pkg::PROD_W-1:0] prod_q;
  logic [mcpv_pkg::COEFF_W-1:0]      rdata;
  logic signed [31:0]                mul_op;

  // compare unit
  logic [15:0]                 cmp_a;
  logic [mcpv_pkg::MAG_W-1:0]  cmp_b;
  logic [mcpv_pkg::CMP_W-1:0]  cmp_prod_q, bound_q;
  logic                        lt_x_q;

  // result
  logic              result_valid_q;
  logic signed [4:0] visibility_q;
  logic [3:0]        color_index_q;
  logic              mark_occupied_q;

  logic [31:0] cam_ext, n_ext;
  logic        cam_enabled, loop_done, take_beat, lt_y, seen;
  logic        load_ok;
  logic signed [ACC_W-1:0] contrib;
  logic signed [31:0] color_int;
  mcpv_pkg::ram_wr_t ram_wr;
  logic [ADDR_W-1:0] waddr, raddr;

  assign busy_o      = (state_q != ST_IDLE);
  assign cfg_ready_o = ~busy_o;
  assign take_beat   = start_i & ~busy_o;

  assign cam_ext     = 32'(cam_q);
  assign n_ext       = (32'(camera_count_q) > MAX_CAMERAS) ? MAX_CAMERAS
                                                           : 32'(camera_count_q);
  assign loop_done   = (cam_ext == n_ext);
  assign cam_enabled = (cam_ext >= mcpv_pkg::MASKED_CAMERAS) ||
                       enable_mask_q[cam_ext[2:0]];

  // ---- coefficient store ----
  assign load_ok     = (32'(camera_index_i) < MAX_CAMERAS) &&
                       (32'(coeff_index_i) < mcpv_pkg::COEFFS_PER_CAMERA);
  assign ram_wr.en   = take_beat && (req_type_i == mcpv_pkg::REQ_LOAD) && load_ok;
  assign ram_wr.data = coeff_value_i;
  assign waddr       = {CAM_W'(camera_index_i), coeff_index_i};
  assign raddr       = {cam_q[CAM_W-1:0], k_q};

  mcpv_coeff_ram #(
    .ADDR_W (ADDR_W)
  ) u_coeff_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .waddr_i (waddr),
    .re_i    (state_q == ST_ISSUE),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // translation slots pass through as coefficient * 1.0
  always_comb begin
    if (s1_k_q < 4'd9) begin
      mul_op = point_q[mcpv_pkg::coeff_col(s1_k_q)];
    end else begin
      mul_op = 32'sh0001_0000;
    end
  end

  // floor to Q16.16 is an arithmetic shift
  assign contrib = ACC_W'(prod_q >>> 16);

  always_comb begin
    case (state_q)
      ST_CMP_Z: begin
        cmp_a = half_sensor_q;
        cmp_b = mcpv_pkg::magnitude(acc_q[2]);
      end
      ST_CMP_X: begin
        cmp_a = focal_length_q;
        cmp_b = mcpv_pkg::magnitude(acc_q[0]);
      end
      default: begin
        cmp_a = focal_length_q;
        cmp_b = mcpv_pkg::magnitude(acc_q[1]);
      end
    endcase
  end

  assign lt_y = (cmp_prod_q < bound_q);
  assign seen = acc_q[2][ACC_W-1] && lt_y && lt_x_q;

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_beat && (req_type_i == mcpv_pkg::REQ_TEST)) begin
          state_d = ST_CAM;
        end
      end
      ST_CAM: begin
        if (loop_done) begin
          state_d = ST_FINISH;
        end else if (cam_enabled) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_q == 4'(mcpv_pkg::COEFFS_PER_CAMERA - 1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_valid_q && !s2_valid_q) begin
          state_d = ST_CMP_Z;
        end
      end
      ST_CMP_Z:  state_d = ST_CMP_X;
      ST_CMP_X:  state_d = ST_CMP_Y;
      ST_CMP_Y:  state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_CAM;
      ST_FINISH: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      camera_count_q  <= mcpv_pkg::CAMERA_COUNT_RST;
      enable_mask_q   <= mcpv_pkg::ENABLE_MASK_RST;
      focal_length_q  <= mcpv_pkg::FOCAL_LENGTH_RST;
      half_sensor_q   <= mcpv_pkg::HALF_SENSOR_RST;
      occ_threshold_q <= mcpv_pkg::OCC_THRESHOLD_RST;
      s1_valid_q      <= 1'b0;
      s2_valid_q      <= 1'b0;
      result_valid_q  <= 1'b0;
    end else begin
      state_q        <= state_d;
      s1_valid_q     <= (state_q == ST_ISSUE);
      s2_valid_q     <= s1_valid_q;
      result_valid_q <= (state_q == ST_FINISH);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          mcpv_pkg::CFG_CAMERA_COUNT:  camera_count_q  <= cfg_data_i[3:0];
          mcpv_pkg::CFG_ENABLE_MASK:   enable_mask_q   <= cfg_data_i[7:0];
          mcpv_pkg::CFG_FOCAL_LENGTH:  focal_length_q  <= cfg_data_i;
          mcpv_pkg::CFG_HALF_SENSOR:   half_sensor_q   <= cfg_data_i;
          mcpv_pkg::CFG_OCC_THRESHOLD: occ_threshold_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
    end
  end

  // ---- datapath ----
  always_ff @(posedge clk_i) begin
    s1_k_q     <= k_q;
    s2_k_q     <= s1_k_q;
    prod_q     <= mcpv_pkg::PROD_W'($signed(rdata)) * mcpv_pkg::PROD_W'(mul_op);
    cmp_prod_q <= mcpv_pkg::CMP_W'(cmp_a) * mcpv_pkg::CMP_W'(cmp_b);

    if (s2_valid_q) begin
      acc_q[mcpv_pkg::coeff_row(s2_k_q)] <= acc_q[mcpv_pkg::coeff_row(s2_k_q)] + contrib;
    end

    case (state_q)
      ST_IDLE: begin
        point_q[0] <= point_x_i;
        point_q[1] <= point_y_i;
        point_q[2] <= point_z_i;
        cam_q      <= '0;
        vis_q      <= '0;
      end
      ST_CAM: begin
        k_q      <= '0;
        acc_q[0] <= '0;
        acc_q[1] <= '0;
        acc_q[2] <= '0;
        if (!loop_done && !cam_enabled) begin
          cam_q <= cam_q + CNT_W'(1);
        end
      end
      ST_ISSUE: begin
        k_q <= k_q + mcpv_pkg::COEFF_SLOT_W'(1);
      end
      ST_CMP_X: begin
        bound_q <= cmp_prod_q;
      end
      ST_CMP_Y: begin
        lt_x_q <= (cmp_prod_q < bound_q);
      end
      ST_DECIDE: begin
        cam_q <= cam_q + CNT_W'(1);
        if (seen) begin
          if (vis_q < 5'sd15) begin
            vis_q <= vis_q + 5'sd1;
          end
        end else if (!acc_q[2][ACC_W-1] && (acc_q[2] != '0) &&
                     (camera_count_q == 4'd1)) begin
          // lone camera looking away from the point
          vis_q <= -5'sd1;
        end
      end
      default: ;
    endcase

    if (state_q == ST_FINISH) begin
      visibility_q    <= vis_q;
      color_index_q   <= color_int[3:0];
      mark_occupied_q <= (vis_q >= $signed({2'b00, occ_threshold_q}));
    end
  end

  always_comb begin
    color_int = vis_q[4] ? 32'sd0 : 32'(vis_q);
    if (color_int > 32'(mcpv_pkg::COLORMAP_ENTRIES - 1)) begin
      color_int = 32'(mcpv_pkg::COLORMAP_ENTRIES - 1);
    end
  end

  assign result_valid_o  = result_valid_q;
  assign visibility_o    = visibility_q;
  assign color_index_o   = color_index_q;
  assign mark_occupied_o = mark_occupied_q;

endmodule

/* src/mcpv_checker.sv */
// ----------------------------------------------------------------------------
// mcpv_checker
// Port-level checks of the visibility counter, bound to the top level.
// ----------------------------------------------------------------------------
module mcpv_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               req_type_i,
  input logic [2:0]         camera_index_i,
  input logic [3:0]         coeff_index_i,
  input logic signed [31:0] coeff_value_i,
  input logic signed [31:0] point_x_i,
  input logic signed [31:0] point_y_i,
  input logic signed [31:0] point_z_i,
  input logic               result_valid_o,
  input logic signed [4:0]  visibility_o,
  input logic [3:0]         color_index_o,
  input logic               mark_occupied_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [7:0]         cfg_index_i,
  input logic [15:0]        cfg_data_i
);

  // a test beat makes the block busy in the cycle after it is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && req_type_i |=> busy_o)
    else $error("test beat did not start a pass");

  // a load beat never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && !req_type_i |=> !result_valid_o)
    else $error("load beat produced a result");

  // one strobe per test beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // a camera seen from behind maps to colour 0 and no occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && visibility_o[4] |-> (color_index_o == 4'd0) && !mark_occupied_o)
    else $error("negative visibility with colour or occupancy set");

endmodule

bind multi_camera_point_visibility mcpv_checker u_mcpv_checker (.*);

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multi_camera_point_visibility. Coefficient loads and
// point tests go in through the start/busy port and registers through the
// config channel. Every point test is predicted here in Q16.16 fixed point,
// and each result strobe is checked field by field against the oldest
// prediction. Directed corner cases come first, then randomised phases with
// different register settings and different amounts of sender idling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 200;
  localparam int          CAMS           = mcpv_pkg::MAX_CAMERAS_DEFAULT;
  localparam int          NCOEFF         = mcpv_pkg::COEFFS_PER_CAMERA;
  localparam int          METRE          = 65536;
  localparam logic [31:0] Q_ONE          = 32'h0001_0000;
  localparam logic [7:0]  CFG_IDX_UNUSED = 8'd5;
  localparam logic [7:0]  CFG_IDX_TOP    = 8'hFF;
  localparam int          N_PHASES       = 6;
  localparam int          PHASE_BEATS    = 140;
  localparam int          IDLE_PCT [N_PHASES] = '{0, 72, 0, 22, 72, 22};

  typedef struct packed {
    logic [4:0] vis;
    logic [3:0] color;
    logic       occupied;
  } vis_result_t;

  typedef struct {
    mcpv_pkg::req_type_e kind;
    logic [2:0]  cam;
    logic [3:0]  slot;
    logic [31:0] coeff;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } beat_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start_i        = 1'b0;
  logic               busy_o;
  logic               req_type_i     = 1'b0;
  logic [2:0]         camera_index_i = '0;
  logic [3:0]         coeff_index_i  = '0;
  logic signed [31:0] coeff_value_i  = '0;
  logic signed [31:0] point_x_i      = '0;
  logic signed [31:0] point_y_i      = '0;
  logic signed [31:0] point_z_i      = '0;
  logic               result_valid_o;
  logic signed [4:0]  visibility_o;
  logic [3:0]         color_index_o;
  logic               mark_occupied_o;
  logic               cfg_valid_i    = 1'b0;
  logic               cfg_ready_o;
  logic [7:0]         cfg_index_i    = '0;
  logic [15:0]        cfg_data_i     = '0;

  // shadow of the block: coefficient store and registers
  logic [31:0] coeff_store [CAMS][NCOEFF];
  logic [3:0]  cam_count_r = mcpv_pkg::CAMERA_COUNT_RST;
  logic [7:0]  en_mask_r   = mcpv_pkg::ENABLE_MASK_RST;
  logic [15:0] focal_r     = mcpv_pkg::FOCAL_LENGTH_RST;
  logic [15:0] half_r      = mcpv_pkg::HALF_SENSOR_RST;
  logic [2:0]  occ_thr_r   = mcpv_pkg::OCC_THRESHOLD_RST;

  vis_result_t visibility_due_q [$];
  vis_result_t due_result;

  int          fail_count      = 0;
  int          beat_count      = 0;
  int          load_count      = 0;
  int          test_count      = 0;
  int          result_count    = 0;
  int          behind_count    = 0;
  int          vis_peak        = 0;
  int          sender_idle_pct = 0;
  int unsigned cycle_count     = 0;

  multi_camera_point_visibility dut (.*);

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic vis_result_t predict_visibility(input logic [31:0] px, py, pz);
    longint      pt [3];
    longint      q [3];
    logic [63:0] mx, my, mz;
    logic [79:0] fx, fy, bound;
    int          n;
    int          vis;
    int          color;
    vis_result_t r;
    pt[0] = longint'($signed(px));
    pt[1] = longint'($signed(py));
    pt[2] = longint'($signed(pz));
    n = (cam_count_r > CAMS) ? CAMS : int'(cam_count_r);
    vis = 0;
    for (int c = 0; c < n; c++) begin
      if (c < mcpv_pkg::MASKED_CAMERAS && !en_mask_r[c]) continue;
      for (int row = 0; row < 3; row++) begin
        q[row] = longint'($signed(coeff_store[c][9 + row]));
        // each product floored to Q16.16 before the sum
        for (int col = 0; col < 3; col++)
          q[row] += (longint'($signed(coeff_store[c][3 * row + col])) * pt[col]) >>> 16;
      end
      mx = (q[0] < 0) ? -q[0] : q[0];
      my = (q[1] < 0) ? -q[1] : q[1];
      mz = (q[2] < 0) ? -q[2] : q[2];
      fx = 80'(focal_r) * 80'(mx);
      fy = 80'(focal_r) * 80'(my);
      bound = 80'(half_r) * 80'(mz);
      if (q[2] < 0) begin
        if (fx < bound && fy < bound && vis < int'(mcpv_pkg::VIS_SAT)) vis++;
      end else if (q[2] > 0 && cam_count_r == 4'd1) begin
        vis = -1;
      end
    end
    color = (vis < 0) ? 0 : vis;
    if (color > int'(mcpv_pkg::COLORMAP_ENTRIES) - 1)
      color = int'(mcpv_pkg::COLORMAP_ENTRIES) - 1;
    r.vis = vis[4:0];
    r.color = color[3:0];
    r.occupied = (vis >= int'(occ_thr_r));
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      result_count++;
      if (visibility_o == -5'sd1) behind_count++;
      if (visibility_o > vis_peak) vis_peak = visibility_o;
      if (visibility_due_q.size() == 0) begin
        $error("unexpected result beat: visibility %0d", visibility_o);
        fail_count++;
      end else begin
        due_result = visibility_due_q.pop_front();
        if (visibility_o !== due_result.vis) begin
          $error("visibility: expected %0d, got %0d", $signed(due_result.vis), visibility_o);
          fail_count++;
        end
        if (color_index_o !== due_result.color) begin
          $error("color_index: expected %0d, got %0d", due_result.color, color_index_o);
          fail_count++;
        end
        if (mark_occupied_o !== due_result.occupied) begin
          $error("mark_occupied: expected %0b, got %0b", due_result.occupied,
                 mark_occupied_o);
          fail_count++;
        end
      end
    end
  end

  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      // mostly short gaps, now and then one that spans a whole test
      repeat (($urandom_range(9) == 0) ? $urandom_range(1, 180) : 1) @(posedge clk_i);
    end
    start_i        <= 1'b1;
    req_type_i     <= b.kind;
    camera_index_i <= b.cam;
    coeff_index_i  <= b.slot;
    coeff_value_i  <= b.coeff;
    point_x_i      <= b.px;
    point_y_i      <= b.py;
    point_z_i      <= b.pz;
    do @(posedge clk_i); while (busy_o);
    beat_count++;
    if (b.kind == mcpv_pkg::REQ_TEST) begin
      visibility_due_q = {visibility_due_q, predict_visibility(b.px, b.py, b.pz)};
      test_count++;
    end else begin
      load_count++;
      if (b.slot < NCOEFF) coeff_store[b.cam][b.slot] = b.coeff;
    end
  endtask

  task automatic send_load(input int cam, input int slot, input logic [31:0] value);
    beat_t b;
    b.kind  = mcpv_pkg::REQ_LOAD;
    b.cam   = 3'(cam);
    b.slot  = 4'(slot);
    b.coeff = value;
    b.px    = $urandom;
    b.py    = $urandom;
    b.pz    = $urandom;
    send_beat(b);
  endtask

  task automatic send_test(input logic [31:0] x, y, z);
    beat_t b;
    b.kind  = mcpv_pkg::REQ_TEST;
    b.cam   = 3'($urandom);
    b.slot  = 4'($urandom);
    b.coeff = $urandom;
    b.px    = x;
    b.py    = y;
    b.pz    = z;
    send_beat(b);
  endtask

  // wait until no result is due and the block has gone quiet
  task automatic settle(input int unsigned tail);
    start_i <= 1'b0;
    while (visibility_due_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] data);
    settle(SETTLE_CYCLES);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      mcpv_pkg::CFG_CAMERA_COUNT:  cam_count_r = data[3:0];
      mcpv_pkg::CFG_ENABLE_MASK:   en_mask_r   = data[7:0];
      mcpv_pkg::CFG_FOCAL_LENGTH:  focal_r     = data;
      mcpv_pkg::CFG_HALF_SENSOR:   half_r      = data;
      mcpv_pkg::CFG_OCC_THRESHOLD: occ_thr_r   = data[2:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 5) return '0;
    if (pick < 65) return 32'(int'($urandom_range(0, 3 * METRE)) - 3 * METRE / 2);
    if (pick < 80) return 32'(int'($urandom_range(0, 128 * METRE)) - 64 * METRE);
    return $urandom;
  endfunction

  // full transform for one camera, slots sent in a scrambled order
  task automatic load_camera(input int cam);
    logic [31:0] coeff [NCOEFF];
    int          cols [3];
    int          a, b, style, step, first;
    style = $urandom_range(9);
    if (style < 6) begin
      // jittered signed axis permutation, camera a few metres from the origin
      a = $urandom_range(2);
      b = (a + 1 + $urandom_range(1)) % 3;
      cols = '{a, b, 3 - a - b};
      foreach (coeff[k]) coeff[k] = 32'(int'($urandom_range(0, 8192)) - 4096);
      for (int r = 0; r < 3; r++)
        coeff[3 * r + cols[r]] += $urandom_range(1) ? Q_ONE : -Q_ONE;
      coeff[9]  = 32'(int'($urandom_range(0, METRE)) - METRE / 2);
      coeff[10] = 32'(int'($urandom_range(0, METRE)) - METRE / 2);
      coeff[11] = 32'(int'($urandom_range(0, 7 * METRE)) - 6 * METRE);
    end else if (style < 9) begin
      foreach (coeff[k])
        coeff[k] = 32'(int'($urandom_range(0, 3 * METRE)) - 3 * METRE / 2);
      for (int k = 9; k < NCOEFF; k++)
        coeff[k] = 32'(int'($urandom_range(0, 8 * METRE)) - 4 * METRE);
    end else begin
      foreach (coeff[k]) coeff[k] = $urandom;
    end
    case ($urandom_range(3))
      0: step = 1;
      1: step = 5;
      2: step = 7;
      default: step = 11;
    endcase
    first = $urandom_range(NCOEFF - 1);
    for (int j = 0; j < NCOEFF; j++)
      send_load(cam, (first + j * step) % NCOEFF, coeff[(first + j * step) % NCOEFF]);
  endtask

  task automatic test_single_camera();
    send_test('0, '0, -5 * METRE);   // no camera counted after reset
    // camera 0: identity rotation, no translation
    for (int k = 0; k < NCOEFF; k++)
      send_load(0, k, (k % 4 == 0) ? Q_ONE : '0);
    // slots beyond the translation are dropped
    send_load(0, 12, 32'hDEAD_BEEF);
    send_load(7, 15, '1);
    write_reg(mcpv_pkg::CFG_CAMERA_COUNT, 16'hFFF1);
    send_test('0, '0, -5 * METRE);
    send_test('0, '0, 5 * METRE);    // single camera behind
    send_test('0, '0, '0);           // on the sensor plane
    send_test(1800, '0, -3118);      // exactly on the frustum edge
    send_test(1799, '0, -3118);
    send_test('0, -1800, -3118);
    send_test(-1799, 1799, -3118);
    send_test(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_load(0, 8, 32'h8000_0000);
    send_test('0, '0, 32'h8000_0000);
    send_load(0, 8, 32'h7FFF_FFFF);
    send_test(32'h7FFF_FFFF, '0, 32'h8000_0000);
    send_load(0, 8, Q_ONE);
  endtask

  task automatic test_config_corners();
    // count saturates; only camera 0 is enabled since only it is loaded
    write_reg(mcpv_pkg::CFG_CAMERA_COUNT, 16'hFFF9);
    write_reg(mcpv_pkg::CFG_ENABLE_MASK, 16'h0001);
    send_test('0, '0, 5 * METRE);    // behind, but not the single-camera case
    send_test('0, '0, -5 * METRE);
    write_reg(mcpv_pkg::CFG_CAMERA_COUNT, 16'd1);
    write_reg(mcpv_pkg::CFG_ENABLE_MASK, '0);
    send_test('0, '0, 5 * METRE);
    send_test('0, '0, -5 * METRE);
    write_reg(mcpv_pkg::CFG_ENABLE_MASK, 16'hFF01);
    write_reg(mcpv_pkg::CFG_FOCAL_LENGTH, '0);
    send_test(32'h4000_0000, 32'hC000_0000, -1);
    write_reg(mcpv_pkg::CFG_HALF_SENSOR, '0);
    send_test('0, '0, -5 * METRE);
    write_reg(mcpv_pkg::CFG_FOCAL_LENGTH, 16'd3118);
    write_reg(mcpv_pkg::CFG_HALF_SENSOR, 16'd1800);
    write_reg(mcpv_pkg::CFG_OCC_THRESHOLD, 16'hFFFF);
    send_test('0, '0, -5 * METRE);
    write_reg(mcpv_pkg::CFG_OCC_THRESHOLD, 16'd1);
    send_test('0, '0, -5 * METRE);
    send_test('0, '0, 5 * METRE);
    write_reg(CFG_IDX_UNUSED, 16'hFFFF);
    write_reg(CFG_IDX_TOP, 16'hFFFF);
    send_test('0, '0, -5 * METRE);
  endtask

  task automatic test_random_phase(input int phase, input int pct, input int n_beats);
    logic [15:0] cnt, mask, focal, half, thr;
    int          stop_at;
    int          pick;
    case (phase)
      0: begin
        cnt = 16'd8; mask = 16'h00FF; focal = 16'd3118; half = 16'd1800; thr = 16'd2;
      end
      1: begin
        cnt = 16'd15; mask = 16'($urandom); focal = 16'd1; half = 16'hFFFF; thr = 16'd7;
      end
      2: begin
        cnt = 16'($urandom_range(2, 7)); mask = 16'($urandom); focal = 16'hFFFF;
        half = 16'd1; thr = 16'($urandom_range(7));
      end
      3: begin
        cnt = 16'd1; mask = 16'h00FF; focal = 16'd3118; half = 16'd1800; thr = '0;
      end
      default: begin
        cnt = 16'($urandom); mask = 16'($urandom); focal = 16'($urandom);
        half = 16'($urandom); thr = 16'($urandom);
      end
    endcase
    write_reg(mcpv_pkg::CFG_CAMERA_COUNT, cnt);
    write_reg(mcpv_pkg::CFG_ENABLE_MASK, mask);
    write_reg(mcpv_pkg::CFG_FOCAL_LENGTH, focal);
    write_reg(mcpv_pkg::CFG_HALF_SENSOR, half);
    write_reg(mcpv_pkg::CFG_OCC_THRESHOLD, thr);
    sender_idle_pct = pct;
    stop_at = beat_count + n_beats;
    while (beat_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 4) load_camera($urandom_range(CAMS - 1));
      else if (pick < 12) send_load($urandom_range(CAMS - 1), $urandom_range(15), $urandom);
      else send_test(rand_coord(), rand_coord(), rand_coord());
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_camera();
    test_config_corners();
    // every camera gets a full transform before more than one camera takes part in a test
    for (int c = 0; c < CAMS; c++) load_camera(c);
    for (int p = 0; p < N_PHASES; p++) test_random_phase(p, IDLE_PCT[p], PHASE_BEATS);
    settle(DRAIN_CYCLES);
    $display("tb_top: %0d beats sent (%0d coefficient loads, %0d point tests), %0d results",
             beat_count, load_count, test_count, result_count);
    $display("tb_top: highest visibility %0d, %0d single-camera-behind results, %0d phases",
             vis_peak, behind_count, N_PHASES);
    if (fail_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
